// ----- hdl/rcfp_pkg.sv -----
// rcfp_pkg: shared constants and types for the RC channel frame parser.
// No dependencies; imported by rc_channel_frame_parser.
package rcfp_pkg;

    localparam int NUM_CHANNELS = 14;
    localparam int CH_W         = 4;
    localparam int POS_W        = 6;

    localparam logic [7:0]       SYNC_FIRST  = 8'h20;
    localparam logic [7:0]       SYNC_SECOND = 8'h40;
    localparam logic [POS_W-1:0] POS_SECOND  = POS_W'(1);
    localparam logic [POS_W-1:0] DATA_START  = POS_W'(2);
    localparam logic [POS_W-1:0] DATA_END    = POS_W'(2 + 2 * NUM_CHANNELS);
    localparam logic [CH_W-1:0]  LAST_CH     = CH_W'(NUM_CHANNELS - 1);

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_READ,
        ST_LOAD
    } rcfp_state_t;

endpackage

// ----- hdl/rc_channel_frame_parser.sv -----
// rc_channel_frame_parser: byte-serial RC frame parser with a channel memory.
// Depends on rcfp_pkg (constants, state type).
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// rx       | in        | rx_valid/rx_stall  | rx_byte[7:0]
// res      | out       | res_valid/res_stall| status, channel_index[3:0],
//          |           |                    | channel_value[15:0], last
//
// One received byte is taken per cycle while collecting and the output slot is free;
// a byte that does not end a frame gives no result. A good frame is read back from
// the channel memory one channel at a time (read, then load the output register),
// each load waiting while res_stall holds the slot; rx_stall is high during readout.
// A bad checksum loads one error result in the cycle the last byte is taken.
// Reset (rst_n low) clears the sync state, position, sum and the output valid; the
// channel memory is not cleared, since every entry is written before a frame emits.
module rc_channel_frame_parser
    import rcfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        status,
    output logic [3:0]  channel_index,
    output logic [15:0] channel_value,
    output logic        last
);

    // Frame collection state
    rcfp_state_t        state_reg, state_next;
    logic               in_sync_reg, in_sync_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [15:0]        sum_reg, sum_next;
    logic [7:0]         low_reg, low_next;
    logic [CH_W-1:0]    ch_reg, ch_next;

    // Output register
    logic               res_valid_reg, res_valid_next;
    logic               status_reg;
    logic [CH_W-1:0]    index_reg;
    logic [15:0]        value_reg;
    logic               last_reg;

    // Channel memory: one entry per channel, registered read
    logic [15:0]        ch_mem [NUM_CHANNELS];
    logic [15:0]        rd_data_reg;

    logic               rx_fire;
    logic               slot_free;
    logic [POS_W-1:0]   data_off;
    logic               is_data;
    logic               frame_end;
    logic               csum_ok;
    logic               wr_en;
    logic [CH_W-1:0]    wr_addr;
    logic               rd_en;
    logic               load_ch;
    logic               load_err;

    // The output slot is free when empty or when its transfer completes this edge.
    assign slot_free = !res_valid_reg || !res_stall;
    assign rx_fire   = rx_valid && !rx_stall;

    assign data_off  = pos_reg - DATA_START;
    assign is_data   = in_sync_reg && (pos_reg >= DATA_START) && (pos_reg < DATA_END);
    assign frame_end = rx_fire && in_sync_reg && (pos_reg > DATA_END);
    // 0xFFFF minus the sum is the bitwise inverse of the sum.
    assign csum_ok   = ({rx_byte, low_reg} == ~sum_reg);

    // Odd data offsets carry the high byte: write the completed channel value.
    assign wr_en   = rx_fire && is_data && data_off[0];
    assign wr_addr = data_off[CH_W:1];

    // Byte-level collection: hunt, check second sync byte, accumulate, hold low byte, end on checksum.
    always_comb
    begin
        in_sync_next = in_sync_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        low_next     = low_reg;
        if (rx_fire)
        begin
            if (!in_sync_reg)
            begin
                if (rx_byte == SYNC_FIRST)
                begin
                    in_sync_next = 1'b1;
                    pos_next     = POS_SECOND;
                    sum_next     = {8'h00, SYNC_FIRST};
                end
            end
            else if (pos_reg == POS_SECOND)
            begin
                // A bad second byte drops sync and is not rechecked as a first byte.
                if (rx_byte == SYNC_SECOND)
                begin
                    pos_next = DATA_START;
                    sum_next = sum_reg + {8'h00, rx_byte};
                end
                else
                begin
                    in_sync_next = 1'b0;
                    pos_next     = '0;
                end
            end
            else if (pos_reg < DATA_END)
            begin
                sum_next = sum_reg + {8'h00, rx_byte};
                if (!data_off[0])
                begin
                    low_next = rx_byte;
                end
                pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg == DATA_END)
            begin
                // Low checksum byte: hold, leave it out of the sum.
                low_next = rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
            else
            begin
                // High checksum byte: frame ends, back to hunting either way.
                in_sync_next = 1'b0;
                pos_next     = '0;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (frame_end && csum_ok)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = (ch_reg == LAST_CH) ? ST_COLLECT : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        rx_stall = 1'b1;
        rd_en    = 1'b0;
        load_ch  = 1'b0;
        load_err = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                // Hold bytes while an undelivered result occupies the output slot.
                rx_stall = !slot_free;
                load_err = frame_end && !csum_ok;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_LOAD:
            begin
                load_ch = slot_free;
            end
            default:
            begin
                rx_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        ch_next = ch_reg;
        if (frame_end)
        begin
            ch_next = '0;
        end
        else if (load_ch)
        begin
            ch_next = ch_reg + CH_W'(1);
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (load_ch || load_err)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            in_sync_reg   <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            low_reg       <= '0;
            ch_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_sync_reg   <= in_sync_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            low_reg       <= low_next;
            ch_reg        <= ch_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Output payload: load a channel value or the error result.
    always_ff @(posedge clk)
    begin
        if (load_err)
        begin
            status_reg <= STATUS_ERR;
            index_reg  <= '0;
            value_reg  <= '0;
            last_reg   <= 1'b1;
        end
        else if (load_ch)
        begin
            status_reg <= STATUS_OK;
            index_reg  <= ch_reg;
            value_reg  <= rd_data_reg;
            last_reg   <= (ch_reg == LAST_CH);
        end
    end

    // Channel memory. Writes happen only while collecting and reads only during
    // readout with the byte channel stalled, so the two never touch the same cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ch_mem[wr_addr] <= {rx_byte, low_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= ch_mem[ch_reg];
        end
    end

    assign res_valid     = res_valid_reg;
    assign status        = status_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign last          = last_reg;

endmodule
